// ----- rtl/heater_safety_monitor_macros.svh -----
// ----------------------------------------------------------------------------
// Heater safety monitor assertion macros
// Shared concurrent assertion forms used by the monitor's modules.
// ----------------------------------------------------------------------------
`ifndef HEATER_SAFETY_MONITOR_MACROS_SVH
`define HEATER_SAFETY_MONITOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSM_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/hsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Heater safety monitor package
// Types, codes and constants shared by the monitor's modules.
// ----------------------------------------------------------------------------
package hsm_pkg;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_OT_MARGIN          = 3'd0;
    localparam logic [2:0] REG_HEATER_MAX_SECONDS = 3'd1;
    localparam logic [2:0] REG_STALE_TIMEOUT      = 3'd2;
    localparam logic [2:0] REG_MISMATCH_LIMIT     = 3'd3;
    localparam logic [2:0] REG_RATE_LIMIT         = 3'd4;

    // Register reset values.
    localparam logic [10:0] OT_MARGIN_RESET          = 11'd80;
    localparam logic [23:0] HEATER_MAX_SECONDS_RESET = 24'd3600;
    localparam logic [15:0] STALE_TIMEOUT_RESET      = 16'd30;
    localparam logic [10:0] MISMATCH_LIMIT_RESET     = 11'd160;
    localparam logic [10:0] RATE_LIMIT_RESET         = 11'd32;

    // Time constants in microseconds.
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [47:0] RATE_MIN_DT  = 48'd100000;

    // Stale threshold: (timeout + 1) seconds, in microseconds, 36 bits.
    localparam int STALE_THRESH_W = 36;
    localparam logic [STALE_THRESH_W-1:0] STALE_THRESH_RESET =
        STALE_THRESH_W'((64'(STALE_TIMEOUT_RESET) + 64'd1) * 64'(USEC_PER_SEC));

    // Sensor plausibility window, -20 to 85 degrees in 1/16 degree.
    localparam logic signed [11:0] RANGE_LOW  = -12'sd320;
    localparam logic signed [11:0] RANGE_HIGH = 12'sd1360;

    // Heater counter saturation value.
    localparam logic [23:0] HEATER_SECONDS_MAX = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        MODE_CHECK   = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_RESTART = 2'd3
    } hsm_mode_t;

    typedef enum logic [2:0] {
        STATUS_OK       = 3'd0,
        STATUS_WARN     = 3'd1,
        STATUS_OVERTEMP = 3'd2,
        STATUS_SENSOR   = 3'd3,
        STATUS_STALE    = 3'd4,
        STATUS_MISMATCH = 3'd5,
        STATUS_TIMEOUT  = 3'd6
    } hsm_status_t;

    // One input item as held in the input register.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [11:0] hot_temp;
        logic signed [11:0] cool_temp;
        logic signed [11:0] target_temp;
        logic               heater_active;
        logic [47:0]        now_time;
    } hsm_item_t;

    // Configuration seen by the evaluation logic.
    typedef struct packed {
        logic [10:0]               ot_margin;
        logic [23:0]               heater_max_seconds;
        logic [15:0]               stale_timeout;
        logic [10:0]               mismatch_limit;
        logic [10:0]               rate_limit;
        logic [STALE_THRESH_W-1:0] stale_thresh;
    } hsm_cfg_t;

endpackage

// ----- rtl/hsm_regs.sv -----
// ----------------------------------------------------------------------------
// Heater safety monitor configuration registers
// APB register file with a registered stale threshold derived from the timeout.
// ----------------------------------------------------------------------------
module hsm_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hsm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [hsm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [hsm_pkg::APB_DATA_W-1:0]     prdata,
    output hsm_pkg::hsm_cfg_t                  cfg
);

    logic [10:0] ot_margin_reg;
    logic [23:0] heater_max_seconds_reg;
    logic [15:0] stale_timeout_reg;
    logic [10:0] mismatch_limit_reg;
    logic [10:0] rate_limit_reg;
    logic [hsm_pkg::STALE_THRESH_W-1:0] stale_thresh_reg;
    logic [hsm_pkg::STALE_THRESH_W-1:0] stale_thresh_next;
    logic [2:0]  reg_index;
    logic        wr_en;

    assign reg_index = paddr[4:2];
    assign wr_en     = psel && penable && pwrite;

    // Register writes on the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ot_margin_reg          <= hsm_pkg::OT_MARGIN_RESET;
            heater_max_seconds_reg <= hsm_pkg::HEATER_MAX_SECONDS_RESET;
            stale_timeout_reg      <= hsm_pkg::STALE_TIMEOUT_RESET;
            mismatch_limit_reg     <= hsm_pkg::MISMATCH_LIMIT_RESET;
            rate_limit_reg         <= hsm_pkg::RATE_LIMIT_RESET;
        end else if (wr_en) begin
            case (reg_index)
                hsm_pkg::REG_OT_MARGIN:          ot_margin_reg          <= pwdata[10:0];
                hsm_pkg::REG_HEATER_MAX_SECONDS: heater_max_seconds_reg <= pwdata[23:0];
                hsm_pkg::REG_STALE_TIMEOUT:      stale_timeout_reg      <= pwdata[15:0];
                hsm_pkg::REG_MISMATCH_LIMIT:     mismatch_limit_reg     <= pwdata[10:0];
                hsm_pkg::REG_RATE_LIMIT:         rate_limit_reg         <= pwdata[10:0];
                default: begin
                end
            endcase
        end
    end

    // An age of N whole seconds exceeds the timeout T when the age in
    // microseconds reaches (T + 1) seconds, so the threshold is kept ready.
    assign stale_thresh_next = hsm_pkg::STALE_THRESH_W'(
        (hsm_pkg::STALE_THRESH_W'(stale_timeout_reg) + hsm_pkg::STALE_THRESH_W'(1))
        * hsm_pkg::STALE_THRESH_W'(hsm_pkg::USEC_PER_SEC));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_thresh_reg <= hsm_pkg::STALE_THRESH_RESET;
        end else begin
            stale_thresh_reg <= stale_thresh_next;
        end
    end

    // Read back.
    always_comb begin
        case (reg_index)
            hsm_pkg::REG_OT_MARGIN:          prdata = {21'd0, ot_margin_reg};
            hsm_pkg::REG_HEATER_MAX_SECONDS: prdata = {8'd0, heater_max_seconds_reg};
            hsm_pkg::REG_STALE_TIMEOUT:      prdata = {16'd0, stale_timeout_reg};
            hsm_pkg::REG_MISMATCH_LIMIT:     prdata = {21'd0, mismatch_limit_reg};
            hsm_pkg::REG_RATE_LIMIT:         prdata = {21'd0, rate_limit_reg};
            default:                         prdata = '0;
        endcase
    end

    assign cfg.ot_margin          = ot_margin_reg;
    assign cfg.heater_max_seconds = heater_max_seconds_reg;
    assign cfg.stale_timeout      = stale_timeout_reg;
    assign cfg.mismatch_limit     = mismatch_limit_reg;
    assign cfg.rate_limit         = rate_limit_reg;
    assign cfg.stale_thresh       = stale_thresh_reg;

endmodule

// ----- rtl/hsm_core.sv -----
// ----------------------------------------------------------------------------
// Heater safety monitor evaluation core
// Monitor state and the single-pass check logic for one item.
// ----------------------------------------------------------------------------
`include "heater_safety_monitor_macros.svh"

module hsm_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  hsm_pkg::hsm_item_t    item,
    input  hsm_pkg::hsm_cfg_t     cfg,
    output hsm_pkg::hsm_status_t  status
);

    logic [23:0]        heater_seconds_reg, heater_seconds_next;
    logic [47:0]        last_pass_time_reg, last_pass_time_next;
    logic signed [11:0] previous_hot_reg, previous_hot_next;
    logic [47:0]        previous_time_reg, previous_time_next;
    logic               previous_valid_reg, previous_valid_next;

    logic               range_fail;
    logic [48:0]        age;
    logic               stale_fail;
    logic signed [12:0] hc_diff;
    logic [11:0]        hc_abs;
    logic               mismatch_fail;
    logic signed [12:0] hp_diff;
    logic [11:0]        hp_abs;
    logic [48:0]        dt_full;
    logic               dt_forward;
    logic [31:0]        rate_lhs;
    logic [41:0]        rate_rhs;
    logic               rate_fail;
    logic signed [13:0] ot_limit;
    logic               over_fail;
    logic               timeout_fail;
    logic signed [12:0] ht_diff;
    logic signed [16:0] ht_ext;
    logic signed [16:0] ht_times10;
    logic [13:0]        off_times7;
    logic               warn;

    // Sensor plausibility window on both zones.
    assign range_fail = (item.hot_temp < hsm_pkg::RANGE_LOW)
                     || (item.hot_temp > hsm_pkg::RANGE_HIGH)
                     || (item.cool_temp < hsm_pkg::RANGE_LOW)
                     || (item.cool_temp > hsm_pkg::RANGE_HIGH);

    // Staleness; a time that has gone backwards is never stale.
    assign age = {1'b0, item.now_time} - {1'b0, last_pass_time_reg};
    assign stale_fail = (cfg.stale_timeout != '0) && !age[48]
                     && (age[47:0] >= {12'd0, cfg.stale_thresh});

    // Hot to cool difference.
    assign hc_diff = $signed({item.hot_temp[11], item.hot_temp})
                   - $signed({item.cool_temp[11], item.cool_temp});
    assign hc_abs  = hc_diff[12] ? 12'(-hc_diff) : hc_diff[11:0];
    assign mismatch_fail = (cfg.mismatch_limit != '0) && (hc_abs > {1'b0, cfg.mismatch_limit});

    // Rate of change. Both readings have passed the range test, so the left
    // side stays below 2^31; an interval of 2^31 us or more can never fail
    // and only its low 31 bits go into the multiplier.
    assign hp_diff = $signed({item.hot_temp[11], item.hot_temp})
                   - $signed({previous_hot_reg[11], previous_hot_reg});
    assign hp_abs  = hp_diff[12] ? 12'(-hp_diff) : hp_diff[11:0];
    assign dt_full = {1'b0, item.now_time} - {1'b0, previous_time_reg};
    assign dt_forward = !dt_full[48] && (dt_full[47:0] > hsm_pkg::RATE_MIN_DT);
    assign rate_lhs = 32'(hp_abs) * 32'(hsm_pkg::USEC_PER_SEC);
    assign rate_rhs = 42'(cfg.rate_limit) * 42'(dt_full[30:0]);
    assign rate_fail = (cfg.rate_limit != '0) && previous_valid_reg && dt_forward
                    && (dt_full[47:31] == '0) && ({10'd0, rate_lhs} > rate_rhs);

    // Overtemperature against setpoint plus margin.
    assign ot_limit  = $signed({{2{item.target_temp[11]}}, item.target_temp})
                     + $signed({3'b000, cfg.ot_margin});
    assign over_fail = $signed({{2{item.hot_temp[11]}}, item.hot_temp}) > ot_limit;

    // Heater on-time limit.
    assign timeout_fail = (cfg.heater_max_seconds != '0)
                       && (heater_seconds_reg >= cfg.heater_max_seconds);

    // Early warning at seven tenths of the margin, compared as 10x against 7x.
    assign ht_diff    = $signed({item.hot_temp[11], item.hot_temp})
                      - $signed({item.target_temp[11], item.target_temp});
    assign ht_ext     = {{4{ht_diff[12]}}, ht_diff};
    assign ht_times10 = (ht_ext <<< 3) + (ht_ext <<< 1);
    assign off_times7 = {cfg.ot_margin, 3'b000} - {3'b000, cfg.ot_margin};
    assign warn       = ht_times10 > $signed({3'b000, off_times7});

    // Status priority and state updates.
    always_comb begin
        status              = hsm_pkg::STATUS_OK;
        heater_seconds_next = heater_seconds_reg;
        last_pass_time_next = last_pass_time_reg;
        previous_hot_next   = previous_hot_reg;
        previous_time_next  = previous_time_reg;
        previous_valid_next = previous_valid_reg;
        case (hsm_pkg::hsm_mode_t'(item.mode))
            hsm_pkg::MODE_CHECK: begin
                if (range_fail) begin
                    status = hsm_pkg::STATUS_SENSOR;
                end else if (stale_fail) begin
                    status = hsm_pkg::STATUS_STALE;
                end else begin
                    last_pass_time_next = item.now_time;
                    if (mismatch_fail) begin
                        status = hsm_pkg::STATUS_MISMATCH;
                    end else if (rate_fail) begin
                        status = hsm_pkg::STATUS_SENSOR;
                    end else begin
                        previous_hot_next   = item.hot_temp;
                        previous_time_next  = item.now_time;
                        previous_valid_next = 1'b1;
                        if (over_fail) begin
                            status = hsm_pkg::STATUS_OVERTEMP;
                        end else if (timeout_fail) begin
                            status = hsm_pkg::STATUS_TIMEOUT;
                        end else if (warn) begin
                            status = hsm_pkg::STATUS_WARN;
                        end
                    end
                end
            end
            hsm_pkg::MODE_TICK: begin
                if (!item.heater_active) begin
                    heater_seconds_next = '0;
                end else if (heater_seconds_reg != hsm_pkg::HEATER_SECONDS_MAX) begin
                    heater_seconds_next = heater_seconds_reg + 24'd1;
                end
            end
            hsm_pkg::MODE_CLEAR: begin
                heater_seconds_next = '0;
            end
            hsm_pkg::MODE_RESTART: begin
                heater_seconds_next = '0;
                last_pass_time_next = item.now_time;
                previous_hot_next   = '0;
                previous_time_next  = '0;
                previous_valid_next = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Monitor state, updated as an item leaves for the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heater_seconds_reg <= '0;
            last_pass_time_reg <= '0;
            previous_hot_reg   <= '0;
            previous_time_reg  <= '0;
            previous_valid_reg <= 1'b0;
        end else if (fire) begin
            heater_seconds_reg <= heater_seconds_next;
            last_pass_time_reg <= last_pass_time_next;
            previous_hot_reg   <= previous_hot_next;
            previous_time_reg  <= previous_time_next;
            previous_valid_reg <= previous_valid_next;
        end
    end

    // The heater count holds at its ceiling while the heater stays on.
    `HSM_ASSERT_NEXT(a_heater_saturates, aclk, aresetn,
        fire && (item.mode == hsm_pkg::MODE_TICK) && item.heater_active
            && (heater_seconds_reg == hsm_pkg::HEATER_SECONDS_MAX),
        heater_seconds_reg == hsm_pkg::HEATER_SECONDS_MAX,
        "heater count left saturation")

    // A restart drops the previous reading and the heater count.
    `HSM_ASSERT_NEXT(a_restart_clears, aclk, aresetn,
        fire && (item.mode == hsm_pkg::MODE_RESTART),
        !previous_valid_reg && (heater_seconds_reg == '0),
        "restart did not clear monitor state")

endmodule

// ----- rtl/heater_safety_monitor.sv -----
// ----------------------------------------------------------------------------
// Heater safety monitor
// Two-sensor heater supervisor with an APB configuration port.
// ----------------------------------------------------------------------------
// The monitor accepts one item per clock cycle and returns one status item for
// each, in order: an item is held in the input register and then passes
// through the evaluation logic into the result register. The single
// evaluation stage, which reads and updates the monitor state as each item
// passes, sets that rate; a stalled result stops the input register and then
// the input channel. The stale threshold is registered from the stale timeout
// register and so takes up a written timeout after that register does.
`include "heater_safety_monitor_macros.svh"

module heater_safety_monitor (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hsm_pkg::APB_DATA_W-1:0] pwdata,
    output logic [hsm_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_mode,
    input  logic signed [11:0]             s_hot_temp,
    input  logic signed [11:0]             s_cool_temp,
    input  logic signed [11:0]             s_target_temp,
    input  logic                           s_heater_active,
    input  logic [47:0]                    s_now_time,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [2:0]                     m_status
);

    hsm_pkg::hsm_cfg_t     cfg;
    hsm_pkg::hsm_item_t    in_item_reg;
    hsm_pkg::hsm_status_t  status;
    logic                  in_vld_reg, in_vld_next;
    logic                  out_vld_reg, out_vld_next;
    logic [2:0]            out_status_reg;
    logic                  out_free;
    logic                  fire;
    logic                  in_take;

    assign pready = 1'b1;

    hsm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Handshake: the input register moves on whenever the result register
    // is empty or being emptied.
    assign out_free = !out_vld_reg || m_ready;
    assign fire     = in_vld_reg && out_free;
    assign s_ready  = !in_vld_reg || out_free;
    assign in_take  = s_valid && s_ready;

    assign in_vld_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_vld_reg);
    assign out_vld_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_item_reg.mode          <= s_mode;
            in_item_reg.hot_temp      <= s_hot_temp;
            in_item_reg.cool_temp     <= s_cool_temp;
            in_item_reg.target_temp   <= s_target_temp;
            in_item_reg.heater_active <= s_heater_active;
            in_item_reg.now_time      <= s_now_time;
        end
    end

    hsm_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .status  (status)
    );

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (fire) begin
            out_status_reg <= status;
        end
    end

    assign m_valid  = out_vld_reg;
    assign m_status = out_status_reg;

    // A held item is kept intact while the result side is blocked.
    `HSM_ASSERT_NEXT(a_in_hold, aclk, aresetn,
        in_vld_reg && !out_free,
        in_vld_reg && $stable(in_item_reg),
        "input register lost an item during a stall")

    // Every evaluated item appears as a result in the next cycle.
    `HSM_ASSERT_NEXT(a_result_follows, aclk, aresetn,
        fire,
        out_vld_reg,
        "evaluated item produced no result")

endmodule

// ----- tb/heater_safety_monitor_checker.sv -----
// ----------------------------------------------------------------------------
// Heater safety monitor checker
// Watches the configuration port and both item channels, predicts the status
// of every accepted item and compares it with the status that comes out.
// ----------------------------------------------------------------------------
module heater_safety_monitor_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [hsm_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [hsm_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [1:0]                     s_mode,
    input  logic signed [11:0]             s_hot_temp,
    input  logic signed [11:0]             s_cool_temp,
    input  logic signed [11:0]             s_target_temp,
    input  logic                           s_heater_active,
    input  logic [47:0]                    s_now_time,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [2:0]                     m_status,
    output int unsigned                    outstanding,
    output int unsigned                    fail_count
);

    // Our own copy of the registers.
    logic [10:0] ot_offset;
    logic [23:0] heater_limit;
    logic [15:0] stale_secs;
    logic [10:0] mismatch_max;
    logic [10:0] rate_max;

    // Our own copy of the monitor state.
    logic [23:0] heater_secs;
    logic [47:0] last_pass_us;
    int          prev_hot;
    logic [47:0] prev_us;
    logic        prev_valid;

    hsm_pkg::hsm_status_t due_status[$];
    hsm_pkg::hsm_status_t want;
    int unsigned errors = 0;

    // Works out the status of one item and moves the monitor state on.
    function automatic hsm_pkg::hsm_status_t next_status(hsm_pkg::hsm_mode_t mode,
            logic signed [11:0] hot_t, logic signed [11:0] cool_t,
            logic signed [11:0] target_t, logic active, logic [47:0] now);
        int hot;
        int cool;
        int target;
        int hot_step;
        longint unsigned dt;
        longint unsigned lhs;
        longint unsigned rhs;
        hot    = hot_t;
        cool   = cool_t;
        target = target_t;

        case (mode)
            hsm_pkg::MODE_TICK: begin
                if (!active)
                    heater_secs = '0;
                else if (heater_secs != hsm_pkg::HEATER_SECONDS_MAX)
                    heater_secs = heater_secs + 1'b1;
                return hsm_pkg::STATUS_OK;
            end
            hsm_pkg::MODE_CLEAR: begin
                heater_secs = '0;
                return hsm_pkg::STATUS_OK;
            end
            hsm_pkg::MODE_RESTART: begin
                heater_secs  = '0;
                last_pass_us = now;
                prev_hot     = 0;
                prev_us      = '0;
                prev_valid   = 1'b0;
                return hsm_pkg::STATUS_OK;
            end
            default: ;
        endcase

        // An implausible reading changes nothing at all.
        if (hot < hsm_pkg::RANGE_LOW || hot > hsm_pkg::RANGE_HIGH ||
            cool < hsm_pkg::RANGE_LOW || cool > hsm_pkg::RANGE_HIGH)
            return hsm_pkg::STATUS_SENSOR;

        // A clock that has gone backwards is never stale.
        if (stale_secs != 0 && now >= last_pass_us &&
            (now - last_pass_us) / hsm_pkg::USEC_PER_SEC > stale_secs)
            return hsm_pkg::STATUS_STALE;
        last_pass_us = now;

        if (mismatch_max != 0 && ((hot > cool) ? hot - cool : cool - hot) > int'(mismatch_max))
            return hsm_pkg::STATUS_MISMATCH;

        // The rate test compares cross products, so no division is needed.
        if (rate_max != 0 && prev_valid && now > prev_us) begin
            dt       = now - prev_us;
            hot_step = (hot > prev_hot) ? hot - prev_hot : prev_hot - hot;
            lhs      = longint'(hot_step) * hsm_pkg::USEC_PER_SEC;
            rhs      = rate_max * dt;
            if (dt > hsm_pkg::RATE_MIN_DT && lhs > rhs)
                return hsm_pkg::STATUS_SENSOR;
        end
        prev_hot   = hot;
        prev_us    = now;
        prev_valid = 1'b1;

        if (hot > target + int'(ot_offset))
            return hsm_pkg::STATUS_OVERTEMP;
        if (heater_limit != 0 && heater_secs >= heater_limit)
            return hsm_pkg::STATUS_TIMEOUT;
        // Warning at seven tenths of the margin.
        if (10 * (hot - target) > 7 * int'(ot_offset))
            return hsm_pkg::STATUS_WARN;
        return hsm_pkg::STATUS_OK;
    endfunction

    // Everything is sampled at the clock edge, before the block updates.
    always @(posedge aclk) begin
        if (!aresetn) begin
            ot_offset    = hsm_pkg::OT_MARGIN_RESET;
            heater_limit = hsm_pkg::HEATER_MAX_SECONDS_RESET;
            stale_secs   = hsm_pkg::STALE_TIMEOUT_RESET;
            mismatch_max = hsm_pkg::MISMATCH_LIMIT_RESET;
            rate_max     = hsm_pkg::RATE_LIMIT_RESET;
            heater_secs  = '0;
            last_pass_us = '0;
            prev_hot     = 0;
            prev_us      = '0;
            prev_valid   = 1'b0;
            due_status.delete();
        end else begin
            // Results come back in order, so each answers the oldest item due.
            if (m_valid && m_ready) begin
                if (due_status.size() == 0) begin
                    $error("status: unexpected item with value %0d", m_status);
                    errors++;
                end else begin
                    want = due_status.pop_front();
                    if (m_status !== want) begin
                        $error("status: expected %0d, actual %0d", want, m_status);
                        errors++;
                    end
                end
            end

            // Register writes land at the access edge.
            if (psel && penable && pwrite && pready) begin
                case (paddr[hsm_pkg::APB_ADDR_W-1:2])
                    hsm_pkg::REG_OT_MARGIN:          ot_offset    = pwdata[10:0];
                    hsm_pkg::REG_HEATER_MAX_SECONDS: heater_limit = pwdata[23:0];
                    hsm_pkg::REG_STALE_TIMEOUT:      stale_secs   = pwdata[15:0];
                    hsm_pkg::REG_MISMATCH_LIMIT:     mismatch_max = pwdata[10:0];
                    hsm_pkg::REG_RATE_LIMIT:         rate_max     = pwdata[10:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready)
                due_status.push_back(next_status(hsm_pkg::hsm_mode_t'(s_mode), s_hot_temp,
                    s_cool_temp, s_target_temp, s_heater_active, s_now_time));
        end
        outstanding <= due_status.size();
        fail_count  <= errors;
    end

endmodule

// ----- tb/heater_safety_monitor_tb.sv -----
// ----------------------------------------------------------------------------
// Heater safety monitor testbench
// Directed checks of the test order and its edge cases, then several register
// settings with random reading sequences, random idling on both channels and
// a checker that predicts every status.
// ----------------------------------------------------------------------------
module heater_safety_monitor_tb;

    localparam int unsigned RUN_LIMIT = 500_000;
    localparam logic [47:0] T0        = 48'd5_000_000;
    localparam logic [47:0] SEC       = 48'd1_000_000;
    localparam int unsigned PER_STAGE = 235;

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [hsm_pkg::APB_ADDR_W-1:0] paddr;
    logic [hsm_pkg::APB_DATA_W-1:0] pwdata;
    logic [hsm_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           s_valid;
    logic                           s_ready;
    logic [1:0]                     s_mode;
    logic signed [11:0]             s_hot_temp;
    logic signed [11:0]             s_cool_temp;
    logic signed [11:0]             s_target_temp;
    logic                           s_heater_active;
    logic [47:0]                    s_now_time;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [2:0]                     m_status;

    int unsigned outstanding;
    int unsigned fail_count;
    int unsigned cycle_count = 0;

    // Stimulus shaping state: a running clock, setpoint and last hot reading.
    logic [47:0] cur_us = T0;
    int          tgt = 400;
    int          last_hot = 400;
    int unsigned cfg_offset = 80;
    int unsigned cfg_stale = 30;
    int unsigned cfg_mismatch = 160;
    int unsigned cfg_rate = 32;

    // Idling control for both sides.
    bit          quiet_tail = 1'b0;
    bit          tx_gaps = 1'b0;
    int unsigned tx_span = 0;
    bit          rx_stalls = 1'b0;
    int unsigned rx_span = 0;
    int unsigned stall_left = 0;

    always #4 aclk = ~aclk;

    heater_safety_monitor uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_hot_temp      (s_hot_temp),
        .s_cool_temp     (s_cool_temp),
        .s_target_temp   (s_target_temp),
        .s_heater_active (s_heater_active),
        .s_now_time      (s_now_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status)
    );

    heater_safety_monitor_checker status_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_hot_temp      (s_hot_temp),
        .s_cool_temp     (s_cool_temp),
        .s_target_temp   (s_target_temp),
        .s_heater_active (s_heater_active),
        .s_now_time      (s_now_time),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .outstanding     (outstanding),
        .fail_count      (fail_count)
    );

    // Cycle count and watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT)
            @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    // Result side: random stall bursts, in stretches that come and go.
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_span   <= $urandom_range(50, 400);
            rx_stalls <= ($urandom_range(0, 2) != 0);
        end else begin
            rx_span <= rx_span - 1;
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (rx_stalls && !quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int rand12();
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(0, 16'hFFFF)), 32'($urandom)};
    endfunction

    // Keeps a temperature near the plausible window, just over its edges at most.
    function automatic int clamp_temp(int v);
        if (v < -322)
            return -322 + int'($urandom_range(0, 40));
        if (v > 1362)
            return 1362 - int'($urandom_range(0, 40));
        return v;
    endfunction

    // Offers one item, after a random gap when gaps are on, and waits for it.
    task automatic send_item(hsm_pkg::hsm_mode_t mode, int hot, int cool, int target,
                             logic active, logic [47:0] now);
        if (tx_span == 0) begin
            tx_span = $urandom_range(20, 80);
            tx_gaps = ($urandom_range(0, 2) != 0);
        end else begin
            tx_span--;
        end
        if (tx_gaps && !quiet_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_hot_temp      <= 12'(hot);
        s_cool_temp     <= 12'(cool);
        s_target_temp   <= 12'(target);
        s_heater_active <= active;
        s_now_time      <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic check_at(int hot, int cool, int target, logic [47:0] now);
        send_item(hsm_pkg::MODE_CHECK, hot, cool, target, 1'($urandom_range(0, 1)), now);
    endtask

    // Stops sending and waits until every status has come back.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] index, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= hsm_pkg::APB_ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
    endtask

    // New register setting while idle, then a restart from a fresh time base.
    task automatic configure(int unsigned offset, int unsigned hmax, int unsigned stale,
                             int unsigned mismatch, int unsigned rate);
        settle();
        apb_write(hsm_pkg::REG_OT_MARGIN, offset);
        apb_write(hsm_pkg::REG_HEATER_MAX_SECONDS, hmax);
        apb_write(hsm_pkg::REG_STALE_TIMEOUT, stale);
        apb_write(hsm_pkg::REG_MISMATCH_LIMIT, mismatch);
        apb_write(hsm_pkg::REG_RATE_LIMIT, rate);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_offset   = offset;
        cfg_stale    = stale;
        cfg_mismatch = mismatch;
        cfg_rate     = rate;
        cur_us       = rand48();
        send_item(hsm_pkg::MODE_RESTART, rand12(), rand12(), rand12(), 1'b0, cur_us);
    endtask

    initial begin : stimulus
        int unsigned stage;
        int unsigned n;
        int unsigned pick;
        int unsigned step;
        int          hot;
        int          cool;
        int          span;
        logic [47:0] now;

        aresetn         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        s_valid         <= 1'b0;
        s_mode          <= hsm_pkg::MODE_CHECK;
        s_hot_temp      <= '0;
        s_cool_temp     <= '0;
        s_target_temp   <= '0;
        s_heater_active <= 1'b0;
        s_now_time      <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset register values.
        send_item(hsm_pkg::MODE_RESTART, 0, 0, 0, 1'b0, T0);
        check_at(400, 400, 400, T0 + SEC);
        check_at(460, 450, 400, T0 + 48'd2_500_000);
        check_at(-320, 1360, 0, T0 + 3 * SEC);
        check_at(-321, 400, 400, T0 + 4 * SEC);
        check_at(400, 1361, 400, T0 + 4 * SEC);
        check_at(-2048, 2047, 400, T0 + 4 * SEC);
        check_at(2047, -2048, 400, T0 + 4 * SEC);
        check_at(1360, 1360, 1360, T0 + 5 * SEC);
        // Clock runs backwards: neither stale nor rate tested.
        check_at(400, 400, 400, T0);
        check_at(400, 400, 400, T0 + 40 * SEC);
        check_at(420, 400, 400, T0 + 48'd30_500_000);
        // Too soon after the last reading for the rate test to apply.
        check_at(480, 480, 400, T0 + 48'd30_550_000);
        check_at(481, 481, 400, T0 + 48'd31_600_000);
        send_item(hsm_pkg::MODE_TICK, rand12(), rand12(), rand12(), 1'b1, rand48());
        send_item(hsm_pkg::MODE_TICK, rand12(), rand12(), rand12(), 1'b0, rand48());
        send_item(hsm_pkg::MODE_CLEAR, rand12(), rand12(), rand12(), 1'b1, rand48());
        check_at(400, 400, 400, '0);
        check_at(400, 400, 400, '1);
        send_item(hsm_pkg::MODE_RESTART, rand12(), rand12(), rand12(), 1'b1, '1);
        check_at(300, 300, 400, '1);
        check_at(456, 456, 400, '1);
        check_at(457, 457, 400, '1);
        send_item(hsm_pkg::MODE_CLEAR, 0, 0, 0, 1'b0, '0);

        // Random part, one register setting per stage.
        for (stage = 0; stage < 8; stage++) begin
            if (stage == 7)
                quiet_tail = 1'b1;
            case (stage)
                1: configure(0, 0, 0, 0, 0);
                2: configure(1600, 24'hFF_FFFF, 16'hFFFF, 1600, 1600);
                3: configure(80, 1, 1, 1, 1);
                4: configure($urandom_range(0, 200), $urandom_range(1, 12),
                             $urandom_range(1, 10), $urandom_range(1, 300),
                             $urandom_range(1, 100));
                5: configure($urandom_range(0, 1600), $urandom_range(0, 24'hFF_FFFF),
                             $urandom_range(0, 16'hFFFF), $urandom_range(0, 1600),
                             $urandom_range(0, 1600));
                6: configure(8, 8, 5, 48, 8);
                7: configure($urandom_range(16, 160), $urandom_range(2, 16),
                             $urandom_range(1, 40), $urandom_range(20, 400),
                             $urandom_range(4, 64));
                default: ;
            endcase

            for (n = 0; n < PER_STAGE; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    // Noise: every field random.
                    send_item(hsm_pkg::hsm_mode_t'($urandom_range(0, 3)), rand12(),
                              rand12(), rand12(), 1'($urandom_range(0, 1)),
                              ($urandom_range(0, 1) != 0) ? rand48() : cur_us);
                end else if (pick < 72) begin
                    // A plausible reading on the running clock.
                    step = $urandom_range(0, 99);
                    if (step < 60)
                        cur_us = cur_us + $urandom_range(100_001, 2_000_000);
                    else if (step < 70)
                        cur_us = cur_us + $urandom_range(0, 100_000);
                    else if (step >= 80 && step < 90)
                        cur_us = cur_us + 48'(cfg_stale + $urandom_range(0, 1)) * SEC
                               + $urandom_range(0, 999_999);
                    else if (step >= 90)
                        cur_us = cur_us + 48'($urandom_range(0, 120)) * SEC;
                    now = (step >= 70 && step < 80) ? cur_us - $urandom_range(1, 3_000_000)
                                                    : cur_us;
                    if ($urandom_range(0, 15) == 0)
                        tgt = int'($urandom_range(0, 1680)) - 320;
                    span = int'(cfg_offset) + 24;
                    if ($urandom_range(0, 1) == 0)
                        hot = tgt + int'($urandom_range(0, 2 * span)) - span;
                    else
                        hot = last_hot + int'($urandom_range(0, 2 * cfg_rate + 8))
                            - int'(cfg_rate) - 4;
                    hot = clamp_temp(hot);
                    if ($urandom_range(0, 4) != 0)
                        cool = hot + int'($urandom_range(0, 2 * cfg_mismatch + 8))
                             - int'(cfg_mismatch) - 4;
                    else
                        cool = int'($urandom_range(0, 1680)) - 320;
                    cool = clamp_temp(cool);
                    last_hot = hot;
                    check_at(hot, cool, tgt, now);
                end else if (pick < 94) begin
                    send_item(hsm_pkg::MODE_TICK, rand12(), rand12(), rand12(),
                              ($urandom_range(0, 32) != 0), rand48());
                end else if (pick < 97) begin
                    send_item(hsm_pkg::MODE_CLEAR, rand12(), rand12(), rand12(),
                              1'($urandom_range(0, 1)), rand48());
                end else begin
                    if ($urandom_range(0, 3) == 0)
                        cur_us = rand48();
                    send_item(hsm_pkg::MODE_RESTART, rand12(), rand12(), rand12(),
                              1'($urandom_range(0, 1)), cur_us);
                end
            end
        end

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- heater_safety_monitor.f -----
+incdir+rtl
rtl/hsm_pkg.sv
rtl/hsm_regs.sv
rtl/hsm_core.sv
rtl/heater_safety_monitor.sv
tb/heater_safety_monitor_checker.sv
tb/heater_safety_monitor_tb.sv
